/* design/load_window_core_count_governor_core_defines.svh */
// Assertion macros shared by the governor checker.
`ifndef LOAD_WINDOW_CORE_COUNT_GOVERNOR_CORE_DEFINES_SVH
`define LOAD_WINDOW_CORE_COUNT_GOVERNOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LWCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwcc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LWCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwcc: next-cycle check failed");

`endif

/* design/lwcc_pkg.sv */
// Shared constants and types of the load-window core-count governor.
package lwcc_pkg;

    localparam int WINDOW_LEN_DEF = 20;
    localparam int CORE_LIMIT_DEF = 16;

    localparam int LOAD_SCALE = 100;
    localparam int HALF_SCALE = 50;

    localparam int SAMPLE_W   = 16;
    localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
    localparam int REG_CNT_W  = 5;
    localparam int TICKS_W    = 16;
    localparam int ACTION_W   = 2;
    // floor((65535 + 50) / 100) = 655 fits in 10 bits for any window length
    localparam int QUOT_W     = 10;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICKS_W-1:0] VERIFY_TICKS_RST = 16'd12000;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CORES    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORES    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERIFY_TICKS = 8'd3;

    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VERIFY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHANGE = 2'd2;

    // One tick handed from the divider stage to the policy stage.
    typedef struct packed {
        logic              fire;
        logic              en;
        logic              mismatch;
        logic [QUOT_W-1:0] up_q;
        logic [QUOT_W-1:0] down_q;
    } step_t;

endpackage

/* design/lwcc_cell.sv */
// One sample cell of the load window shift chain.
module lwcc_cell
    import lwcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic [SAMPLE_W-1:0] d,
    output logic [SAMPLE_W-1:0] q
);

    logic [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

/* design/lwcc_policy.sv */
// Hysteresis, clamp and verify policy; holds online count and verify state.
module lwcc_policy
    import lwcc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int CORE_LIMIT = CORE_LIMIT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  step_t                              step,
    input  logic                               arm,
    input  logic [$clog2(CORE_LIMIT+1)-1:0]    min_cnt,
    input  logic [$clog2(CORE_LIMIT+1)-1:0]    max_cnt,
    input  logic [TICKS_W-1:0]                 verify_ticks,
    output logic [ACTION_W-1:0]                res_action,
    output logic [$clog2(CORE_LIMIT+1)-1:0]    res_target,
    output logic [$clog2(CORE_LIMIT+1)-1:0]    res_online
);

    localparam int CNT_W = $clog2(CORE_LIMIT + 1);

    logic [TICKS_W-1:0] cd_reg;
    logic [TICKS_W-1:0] cd_next;
    logic               pend_reg;
    logic               pend_next;
    logic [CNT_W-1:0]   online_reg;
    logic [CNT_W-1:0]   online_next;

    logic [QUOT_W-1:0]  min_w;
    logic [QUOT_W-1:0]  max_w;
    logic [QUOT_W-1:0]  on_w;
    logic [QUOT_W-1:0]  up_c;
    logic [QUOT_W-1:0]  down_c;
    logic [TICKS_W-1:0] cd_dec;
    logic [CNT_W-1:0]   tgt;

    always_comb
    begin
        min_w = QUOT_W'(min_cnt);
        max_w = QUOT_W'(max_cnt);
        on_w  = QUOT_W'(online_reg);

        up_c = (step.up_q > max_w) ? max_w : step.up_q;
        if (up_c < min_w)
        begin
            up_c = min_w;
        end
        down_c = (step.down_q > max_w) ? max_w : step.down_q;
        if (down_c < min_w)
        begin
            down_c = min_w;
        end

        // grow only at or above N+0.5, shrink only below it
        if (up_c > on_w)
        begin
            tgt = CNT_W'(up_c);
        end
        else if (down_c < on_w)
        begin
            tgt = CNT_W'(down_c);
        end
        else
        begin
            tgt = online_reg;
        end

        cd_dec = (cd_reg != '0) ? cd_reg - TICKS_W'(1) : cd_reg;

        pend_next   = pend_reg;
        cd_next     = cd_reg;
        online_next = online_reg;
        res_action  = ACT_NONE;
        if (step.en)
        begin
            cd_next = cd_dec;
            if (pend_reg)
            begin
                if (cd_dec == '0)
                begin
                    res_action  = ACT_VERIFY;
                    pend_next   = 1'b0;
                    online_next = tgt;
                end
            end
            else if (tgt != online_reg)
            begin
                res_action  = ACT_CHANGE;
                online_next = tgt;
                if (step.mismatch)
                begin
                    pend_next = 1'b1;
                    cd_next   = verify_ticks;
                end
            end
        end

        res_target = step.en ? tgt : '0;
        res_online = online_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg     <= TICKS_W'(WINDOW_LEN);
            pend_reg   <= 1'b1;
            online_reg <= '0;
        end
        else if (arm)
        begin
            cd_reg   <= TICKS_W'(WINDOW_LEN);
            pend_reg <= 1'b1;
        end
        else if (step.fire)
        begin
            cd_reg     <= cd_next;
            pend_reg   <= pend_next;
            online_reg <= online_next;
        end
    end

endmodule

/* design/load_window_core_count_governor_core.sv */
// Top level of the load-window core-count governor.
// Takes one tick beat per clock when not stalled: a beat is accepted whenever in_valid is high
// and in_stall is low, and its result reaches the output register through three register
// stages: window chain and running sum, reciprocal divider, policy/output register. Throughput is
// one beat per cycle; it drops only while the downstream side holds out_stall, which backs up
// through the three registered stages to in_stall. The load window is a chain of WINDOW_LEN
// sample cells that shifts once per enabled tick; the cell at the far end is the sample that
// leaves the window sum. The average and the N+/-0.5 thresholds are folded into two constant
// divisions of the window sum by WINDOW_LEN*100, each done with one reciprocal multiplier.
// Configuration writes are taken every cycle (cfg_ready is tied high) and must be issued
// only while no beat is in flight. No clearing pass is needed after reset.
module load_window_core_count_governor_core
    import lwcc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int CORE_LIMIT = CORE_LIMIT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // tick input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [SAMPLE_W-1:0]             load_sample,
    input  logic                            cores_mismatch,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ACTION_W-1:0]             action,
    output logic [$clog2(CORE_LIMIT+1)-1:0] target_cores,
    output logic [$clog2(CORE_LIMIT+1)-1:0] online_cores,
    // register write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data
);

    localparam int CNT_W       = $clog2(CORE_LIMIT + 1);
    localparam int SUM_W       = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
    localparam int HALF_BIAS   = WINDOW_LEN * HALF_SCALE;
    localparam int DIVISOR     = WINDOW_LEN * LOAD_SCALE;
    localparam int NUM_W       = $clog2(WINDOW_LEN * SAMPLE_MAX + HALF_BIAS + 1);
    localparam int DIV_W       = $clog2(DIVISOR + 1);
    // shift of NUM_W + DIV_W makes ceil(2^s / d) exact for every numerator below 2^NUM_W
    localparam int RECIP_SHIFT = NUM_W + DIV_W;
    localparam int RECIP_W     = NUM_W + 2;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // ---------------- configuration registers ----------------
    logic                 enable_reg;
    logic [CNT_W-1:0]     min_reg;
    logic [CNT_W-1:0]     min_next;
    logic [CNT_W-1:0]     max_reg;
    logic [CNT_W-1:0]     max_next;
    logic [TICKS_W-1:0]   vticks_reg;
    logic                 cfg_wr;
    logic                 arm;
    logic [QUOT_W-1:0]    mn;
    logic [QUOT_W-1:0]    mx;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    // every write of 1 to enable re-arms the startup verify
    assign arm       = cfg_wr && (cfg_index == REG_ENABLE) && cfg_data[0];

    // Limits are sanitized together on a write to either: raise to 1, cap at CORE_LIMIT,
    // then keep min at or below max.
    always_comb
    begin
        mn = (cfg_index == REG_MIN_CORES) ? QUOT_W'(cfg_data[REG_CNT_W-1:0]) : QUOT_W'(min_reg);
        mx = (cfg_index == REG_MAX_CORES) ? QUOT_W'(cfg_data[REG_CNT_W-1:0]) : QUOT_W'(max_reg);
        if (mn < QUOT_W'(1))
        begin
            mn = QUOT_W'(1);
        end
        if (mx < QUOT_W'(1))
        begin
            mx = QUOT_W'(1);
        end
        if (mn > QUOT_W'(CORE_LIMIT))
        begin
            mn = QUOT_W'(CORE_LIMIT);
        end
        if (mx > QUOT_W'(CORE_LIMIT))
        begin
            mx = QUOT_W'(CORE_LIMIT);
        end
        if (mn > mx)
        begin
            mn = mx;
        end
        min_next = CNT_W'(mn);
        max_next = CNT_W'(mx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            min_reg    <= CNT_W'(1);
            max_reg    <= CNT_W'(CORE_LIMIT);
            vticks_reg <= VERIFY_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_ENABLE:
                begin
                    enable_reg <= cfg_data[0];
                end
                REG_MIN_CORES, REG_MAX_CORES:
                begin
                    min_reg <= min_next;
                    max_reg <= max_next;
                end
                REG_VERIFY_TICKS:
                begin
                    vticks_reg <= cfg_data[TICKS_W-1:0];
                end
                default:
                begin
                    // unknown index: dropped
                end
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic s1_v_reg;
    logic s2_v_reg;
    logic out_v_reg;
    logic out_load;
    logic s2_move;
    logic s1_move;
    logic in_acc;

    assign out_load = !out_v_reg || !out_stall;
    assign s2_move  = s2_v_reg && out_load;
    assign s1_move  = s1_v_reg && (!s2_v_reg || s2_move);
    assign in_stall = s1_v_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;

    // ---------------- stage 1: window chain and running sum ----------------
    logic                shift_en;
    logic [SAMPLE_W-1:0] link [WINDOW_LEN+1];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                s1_en_reg;
    logic                s1_mis_reg;

    assign shift_en = in_acc && enable_reg;
    assign link[0]  = load_sample;

    for (genvar g = 0; g < WINDOW_LEN; g++)
    begin : g_cell
        lwcc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift_en),
            .d     (link[g]),
            .q     (link[g+1])
        );
    end

    // oldest sample leaves the sum as the new one enters
    assign sum_next = sum_reg - SUM_W'(link[WINDOW_LEN]) + SUM_W'(load_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            s1_v_reg <= 1'b0;
        end
        else
        begin
            if (shift_en)
            begin
                sum_reg <= sum_next;
            end
            if (in_acc)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_en_reg  <= enable_reg;
            s1_mis_reg <= cores_mismatch;
        end
    end

    // ---------------- stage 2: threshold quotients ----------------
    // up = floor((sum - W*50) / (W*100)), down = floor((sum + W*50) / (W*100)),
    // which equal the thresholds taken on the integer average.
    logic [NUM_W-1:0]  up_num;
    logic [NUM_W-1:0]  down_num;
    logic [PROD_W-1:0] up_prod;
    logic [PROD_W-1:0] down_prod;
    logic              s2_en_reg;
    logic              s2_mis_reg;
    logic [QUOT_W-1:0] up_q_reg;
    logic [QUOT_W-1:0] down_q_reg;

    always_comb
    begin
        up_num    = (NUM_W'(sum_reg) >= NUM_W'(HALF_BIAS))
                  ? NUM_W'(sum_reg) - NUM_W'(HALF_BIAS) : '0;
        down_num  = NUM_W'(sum_reg) + NUM_W'(HALF_BIAS);
        up_prod   = PROD_W'(up_num) * PROD_W'(RECIP);
        down_prod = PROD_W'(down_num) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            s2_v_reg <= 1'b1;
        end
        else if (s2_move)
        begin
            s2_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_en_reg  <= s1_en_reg;
            s2_mis_reg <= s1_mis_reg;
            up_q_reg   <= up_prod[RECIP_SHIFT +: QUOT_W];
            down_q_reg <= down_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    // ---------------- stage 3: policy and output register ----------------
    step_t               step;
    logic [ACTION_W-1:0] res_action;
    logic [CNT_W-1:0]    res_target;
    logic [CNT_W-1:0]    res_online;
    logic [ACTION_W-1:0] action_reg;
    logic [CNT_W-1:0]    target_reg;
    logic [CNT_W-1:0]    online_reg;

    assign step.fire     = s2_move;
    assign step.en       = s2_en_reg;
    assign step.mismatch = s2_mis_reg;
    assign step.up_q     = up_q_reg;
    assign step.down_q   = down_q_reg;

    lwcc_policy #(
        .WINDOW_LEN (WINDOW_LEN),
        .CORE_LIMIT (CORE_LIMIT)
    ) u_policy (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .arm          (arm),
        .min_cnt      (min_reg),
        .max_cnt      (max_reg),
        .verify_ticks (vticks_reg),
        .res_action   (res_action),
        .res_target   (res_target),
        .res_online   (res_online)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_load)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            action_reg <= res_action;
            target_reg <= res_target;
            online_reg <= res_online;
        end
    end

    assign out_valid    = out_v_reg;
    assign action       = action_reg;
    assign target_cores = target_reg;
    assign online_cores = online_reg;

endmodule

/* design/lwcc_checker.sv */
// Port-level checker for the governor, bound to the top level.
`include "load_window_core_count_governor_core_defines.svh"

module lwcc_checker
    import lwcc_pkg::*;
#(
    parameter int CORE_LIMIT = CORE_LIMIT_DEF
)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [ACTION_W-1:0]             action,
    input logic [$clog2(CORE_LIMIT+1)-1:0] target_cores,
    input logic [$clog2(CORE_LIMIT+1)-1:0] online_cores
);

    // a held result beat keeps its payload
    `LWCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(action) && $stable(target_cores) && $stable(online_cores))

    // verify and change both leave the recorded count at the target
    `LWCC_ASSERT_IMPL(a_act_online, out_valid && (action == ACT_VERIFY || action == ACT_CHANGE), online_cores == target_cores)

    // a target that drives an action is at least the sanitized minimum of one
    `LWCC_ASSERT_IMPL(a_act_target, out_valid && action != ACT_NONE, target_cores != '0)

    // with the output register empty the whole pipe drains, so the input is open
    `LWCC_ASSERT_IMPL(a_in_open, !out_valid, !in_stall)

endmodule

bind load_window_core_count_governor_core lwcc_checker #(
    .CORE_LIMIT (CORE_LIMIT)
) u_lwcc_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the load-window core-count governor: directed table, then random ticks.
module tb;
    import lwcc_pkg::*;

    localparam int WIN         = WINDOW_LEN_DEF;
    localparam int CORES       = CORE_LIMIT_DEF;
    localparam int CNT_W       = $clog2(CORES + 1);
    localparam int SUM_W       = 21;
    // Pipeline is three registers deep; give it some slack after the last beat.
    localparam int TAIL_CYCLES = 10;
    // Quiet cycles allowed before the run is declared hung. The worst legal gap is a run of
    // receiver stalls or sender idle cycles at 47 percent, which never gets near this.
    localparam int QUIET_LIMIT = 2000;
    localparam int BLOCKS      = 10;
    localparam int BLOCK_TICKS = 215;
    // Block with the governor switched off: its ticks are ignored, so keep it short.
    localparam int OFF_BLOCK   = 5;
    localparam int OFF_TICKS   = 30;

    // One result beat: what the governor decided on a tick.
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [CNT_W-1:0]    tgt;
        logic [CNT_W-1:0]    onl;
    } decision_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

    // Directed table row: a register write or a tick, with an optional hand-typed result.
    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;   // register value, or load sample on a tick
        logic                  mism;
        bit                    typed;
        decision_t             want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   load_sample = '0;
    logic                  cores_mismatch = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ACTION_W-1:0]   action;
    logic [CNT_W-1:0]      target_cores;
    logic [CNT_W-1:0]      online_cores;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the governor: registers and window state.
    bit                    gov_en;
    logic [REG_CNT_W-1:0]  gov_min;
    logic [REG_CNT_W-1:0]  gov_max;
    logic [TICKS_W-1:0]    gov_vticks;
    logic [SAMPLE_W-1:0]   win_ring [WIN];
    logic [SUM_W-1:0]      win_sum;
    int                    win_pos;
    logic [TICKS_W-1:0]    verify_cnt;
    bit                    verify_armed;
    logic [CNT_W-1:0]      online_cnt;

    decision_t             pending_decisions [$];
    plan_row_t             plan [$];

    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    mismatches = 0;
    int                    beats_checked = 0;
    int                    ticks_sent = 0;
    int                    changes_seen = 0;
    int                    verifies_seen = 0;
    int                    quiet_cycles = 0;

    always #2 clk = ~clk;

    load_window_core_count_governor_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .load_sample    (load_sample),
        .cores_mismatch (cores_mismatch),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .target_cores   (target_cores),
        .online_cores   (online_cores),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ---------------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------------

    // Order matters: raise to 1, cap at the core limit, then pull min under max.
    function automatic void fix_limits();
        if (gov_min < 1) gov_min = REG_CNT_W'(1);
        if (gov_max < 1) gov_max = REG_CNT_W'(1);
        if (gov_min > CORES) gov_min = REG_CNT_W'(CORES);
        if (gov_max > CORES) gov_max = REG_CNT_W'(CORES);
        if (gov_min > gov_max) gov_min = gov_max;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_ENABLE: begin
                gov_en = d[0];
                // any write of 1, repeated or not, re-arms the startup verify
                if (d[0])
                begin
                    verify_armed = 1'b1;
                    verify_cnt   = TICKS_W'(WIN);
                end
            end
            REG_MIN_CORES: begin
                gov_min = d[REG_CNT_W-1:0];
                fix_limits();
            end
            REG_MAX_CORES: begin
                gov_max = d[REG_CNT_W-1:0];
                fix_limits();
            end
            REG_VERIFY_TICKS: gov_vticks = d[TICKS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int clamp_cores(int n);
        if (n > int'(gov_max)) n = int'(gov_max);
        if (n < int'(gov_min)) n = int'(gov_min);
        return n;
    endfunction

    // Advances the shadow state by one tick and returns the decision it produces.
    function automatic decision_t gov_tick(logic [SAMPLE_W-1:0] s, logic m);
        decision_t d;
        int        avg;
        int        up_n;
        int        down_n;
        int        tgt;
        d     = '0;
        d.onl = online_cnt;
        if (!gov_en) return d;

        win_sum           = win_sum - SUM_W'(win_ring[win_pos]) + SUM_W'(s);
        win_ring[win_pos] = s;
        win_pos           = (win_pos + 1) % WIN;
        if (verify_cnt != 0) verify_cnt = verify_cnt - TICKS_W'(1);

        // grow only at N+0.5 tasks or above, shrink only below N+0.5
        avg    = int'(win_sum) / WIN;
        up_n   = clamp_cores((avg >= HALF_SCALE) ? (avg - HALF_SCALE) / LOAD_SCALE : 0);
        down_n = clamp_cores((avg + HALF_SCALE) / LOAD_SCALE);
        if (up_n > int'(online_cnt)) tgt = up_n;
        else if (down_n < int'(online_cnt)) tgt = down_n;
        else tgt = int'(online_cnt);
        d.tgt = tgt[CNT_W-1:0];

        if (verify_armed)
        begin
            if (verify_cnt == 0)
            begin
                d.act        = ACT_VERIFY;
                verify_armed = 1'b0;
                online_cnt   = tgt[CNT_W-1:0];
            end
        end
        else if (tgt != int'(online_cnt))
        begin
            d.act = ACT_CHANGE;
            // mismatch only matters on a change
            if (m)
            begin
                verify_armed = 1'b1;
                verify_cnt   = gov_vticks;
            end
            online_cnt = tgt[CNT_W-1:0];
        end
        d.onl = online_cnt;
        return d;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------------------------

    // Leaves cfg_valid high; the next tick beat drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
    endtask

    // Sends one tick beat after random idle cycles; leaves in_valid high once accepted.
    task automatic send_tick(input logic [SAMPLE_W-1:0] s, input logic m,
                             input bit typed, input decision_t want);
        decision_t pred;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        load_sample    <= s;
        cores_mismatch <= m;
        do @(posedge clk); while (in_stall);
        pred = gov_tick(s, m);
        if (pred.act == ACT_CHANGE) changes_seen++;
        if (pred.act == ACT_VERIFY) verifies_seen++;
        pending_decisions.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // Stop sending and wait for every outstanding decision to come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
    endtask

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        plan_row_t r;
        r       = '{kind: ROW_CFG, default: '0};
        r.idx   = idx;
        r.data  = d;
        plan.push_back(r);
    endfunction

    function automatic void plan_tick(logic [SAMPLE_W-1:0] s, logic m, bit typed,
                                      logic [ACTION_W-1:0] a, int t, int o);
        plan_row_t r;
        r        = '{kind: ROW_TICK, default: '0};
        r.data   = s;
        r.mism   = m;
        r.typed  = typed;
        r.want   = '{a, t[CNT_W-1:0], o[CNT_W-1:0]};
        plan.push_back(r);
    endfunction

    // ---------------------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ---------------------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        decision_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decisions.size() == 0)
            begin
                $display("%0t: unexpected result beat: action=%0d target=%0d online=%0d",
                         $time, action, target_cores, online_cores);
                mismatches++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                beats_checked++;
                if ({action, target_cores, online_cores} !== want)
                begin
                    $display("%0t: expected action=%0d target=%0d online=%0d, got %0d/%0d/%0d",
                             $time, want.act, want.tgt, want.onl,
                             action, target_cores, online_cores);
                    mismatches++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Hang detector: any accepted beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------------
    initial
    begin : stimulus
        int                   lvl;
        int                   smp;
        int                   r;
        int                   n_ticks;
        int                   mn;
        int                   mx;
        logic [TICKS_W-1:0]   vt;
        logic [SAMPLE_W-1:0]  s;

        // shadow state at reset
        gov_en       = 1'b0;
        gov_min      = REG_CNT_W'(1);
        gov_max      = REG_CNT_W'(CORES);
        gov_vticks   = VERIFY_TICKS_RST;
        foreach (win_ring[i]) win_ring[i] = '0;
        win_sum      = '0;
        win_pos      = 0;
        verify_cnt   = TICKS_W'(WIN);
        verify_armed = 1'b1;
        online_cnt   = '0;

        // Directed table. Hand-typed results only where they are obvious; the rest
        // go through the predictor.
        plan_tick(16'hFFFF, 1'b1, 1'b1, ACT_NONE, 0, 0);     // off after reset: ignored
        plan_tick(16'h0000, 1'b0, 1'b1, ACT_NONE, 0, 0);
        plan_cfg(REG_VERIFY_TICKS, 16'h0000);                 // zero re-arm countdown
        plan_cfg(REG_MIN_CORES, 16'h0000);                    // raised to 1
        plan_cfg(REG_MAX_CORES, 16'hFFFF);                    // 31 in the low bits, capped
        plan_cfg(8'hFF, 16'hA5A5);                            // unknown index, no effect
        plan_cfg(REG_ENABLE, 16'h0001);
        // fill the window with alternating extremes; the startup verify is still
        // counting down, so the mismatch flags are ignored
        for (int i = 0; i < WIN - 1; i++)
            plan_tick((i % 2 == 0) ? 16'hFFFF : 16'h0000, 1'(i % 2), 1'b0, ACT_NONE, 0, 0);
        plan_tick(16'h0000, 1'b1, 1'b1, ACT_VERIFY, CORES, CORES);   // countdown hits zero
        plan_cfg(REG_MAX_CORES, 16'h0001);                    // max down to 1, min already there
        plan_tick(16'hFFFF, 1'b1, 1'b1, ACT_CHANGE, 1, 1);    // drop to 1, mismatch re-arms
        plan_tick(16'h0000, 1'b0, 1'b1, ACT_VERIFY, 1, 1);    // zero ticks: verify at once
        plan_cfg(REG_ENABLE, 16'h0000);
        plan_tick(16'h1234, 1'b1, 1'b1, ACT_NONE, 0, 1);      // off: count held

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_tick(plan[i].data, plan[i].mism, plan[i].typed, plan[i].want);
        end

        // Random part: blocks of ticks, each under its own register setting and its own
        // mix of sender idling and receiver stalls.
        lvl = 400;
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            drain();
            case (blk % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            case (blk)
                0: begin mn = 1;  mx = CORES; vt = 16'hFFFF; end
                1: begin mn = 31; mx = CORES; vt = 16'h0000; end
                2: begin mn = 1;  mx = 1;     vt = TICKS_W'($urandom_range(0, 40)); end
                default: begin
                    mn = $urandom_range(0, 31);
                    mx = $urandom_range(0, 31);
                    vt = TICKS_W'($urandom_range(0, 40));
                end
            endcase
            write_reg(REG_MIN_CORES, CFG_DATA_W'(mn));
            write_reg(REG_MAX_CORES, CFG_DATA_W'(mx));
            write_reg(REG_VERIFY_TICKS, vt);
            if (blk == 3) write_reg(8'h04, CFG_DATA_W'($urandom_range(0, 65535)));
            write_reg(REG_ENABLE, (blk == OFF_BLOCK) ? 16'h0000 : 16'h0001);
            n_ticks = (blk == OFF_BLOCK) ? OFF_TICKS : BLOCK_TICKS;

            for (int k = 0; k < n_ticks; k++)
            begin
                // mostly a wandering load level around the core thresholds, with some
                // full-range samples and extremes mixed in
                r = $urandom_range(0, 99);
                if (r < 4)
                    s = SAMPLE_W'($urandom_range(0, 65535));
                else if (r < 6)
                    s = (r == 4) ? 16'hFFFF : 16'h0000;
                else
                begin
                    if (r == 99) lvl = $urandom_range(0, 1800);
                    lvl = lvl + int'($urandom_range(0, 240)) - 120;
                    if (lvl < 0) lvl = 0;
                    if (lvl > 1800) lvl = 1800;
                    smp = lvl + int'($urandom_range(0, 100)) - 50;
                    s = (smp < 0) ? 16'h0000 : smp[SAMPLE_W-1:0];
                end
                send_tick(s, ($urandom_range(0, 3) == 0), 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d ticks, %0d result beats checked: %0d core-count changes, %0d verifies,",
                 ticks_sent, beats_checked, changes_seen, verifies_seen);
        $display("over %0d register settings and four idle/stall mixes; %0d mismatches.",
                 BLOCKS + 1, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/lwcc_pkg.sv
design/lwcc_cell.sv
design/lwcc_policy.sv
design/load_window_core_count_governor_core.sv
design/lwcc_checker.sv
sim/tb.sv
